// ===== hw/rtl/dwc_pkg.sv =====
// ----------------------------------------------------------------------------
// dwc_pkg
// Shared widths, request codes and status codes for the deque with cursor.
// ----------------------------------------------------------------------------
package dwc_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int DATA_W_DEF = 32;

  localparam int REQ_W   = 4;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 2;

  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 4'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 4'd1;
  localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 4'd2;
  localparam logic [REQ_W-1:0] REQ_POP_BACK   = 4'd3;
  localparam logic [REQ_W-1:0] REQ_HEAD       = 4'd4;
  localparam logic [REQ_W-1:0] REQ_TAIL       = 4'd5;
  localparam logic [REQ_W-1:0] REQ_NEXT       = 4'd6;
  localparam logic [REQ_W-1:0] REQ_PREV       = 4'd7;
  localparam logic [REQ_W-1:0] REQ_FIND       = 4'd8;
  localparam logic [REQ_W-1:0] REQ_CLEAR      = 4'd9;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

endpackage

// ===== hw/rtl/deque_with_cursor.sv =====
// ----------------------------------------------------------------------------
// deque_with_cursor
// Bounded double-ended queue in a ring memory, with a cursor over the elements.
// ----------------------------------------------------------------------------
// One request at a time. For every request except find, the accept cycle
// updates the ring pointers and does the ring write and cursor read on the
// single memory; S_FIN then loads the result register once the output is
// free. Find scans the ring one entry per cycle through the memory's read
// port: a hit reads the found word again and goes to S_FIN, a miss parks the
// cursor on the tail and reports no data. The result register frees the
// memory side, but a new request is taken only once the previous one has
// moved into it. No clearing pass after reset.
module deque_with_cursor #(
  parameter int DEPTH  = dwc_pkg::DEPTH_DEF,
  parameter int DATA_W = dwc_pkg::DATA_W_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [dwc_pkg::REQ_W-1:0]        req_type,
  input  logic [dwc_pkg::VALUE_W-1:0]      value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [dwc_pkg::VALUE_W-1:0]      data,
  output logic                             data_valid,
  output logic [dwc_pkg::STAT_W-1:0]       status,
  output logic [$clog2(DEPTH+1)-1:0]       count
);

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int OUT_W  = dwc_pkg::VALUE_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_FIND = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]        state, state_next;
  logic [IDX_W-1:0]  head, head_next;
  logic [CNT_W-1:0]  cnt, cnt_next;
  logic [IDX_W-1:0]  cur, cur_next;
  logic              cur_valid, cur_valid_next;
  logic              hide, hide_next;
  logic [dwc_pkg::STAT_W-1:0] stat, stat_next;
  logic [DATA_W-1:0] key, key_next;
  logic [CNT_W-1:0]  scan_off, scan_off_next;
  logic              pend, pend_next;
  logic [IDX_W-1:0]  pend_off, pend_off_next;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata;
  logic              we, re;
  logic [IDX_W-1:0]  waddr, raddr;
  logic [DATA_W-1:0] wdata;

  logic accept, load_out, to_find, empty, full, match, last;

  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] h,
                                               input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(h) + SUM_W'(off);
    if (s >= SUM_W'(DEPTH)) s = s - SUM_W'(DEPTH);
    return IDX_W'(s);
  endfunction

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign load_out = (state == S_FIN) && (!out_valid || !out_stall);
  assign empty    = (cnt == '0);
  assign full     = (cnt == CNT_W'(DEPTH));
  assign match    = pend && (rdata == key);
  assign last     = pend && (CNT_W'(pend_off) == cnt - CNT_W'(1));

  always_comb begin
    state_next     = state;
    head_next      = head;
    cnt_next       = cnt;
    cur_next       = cur;
    cur_valid_next = cur_valid;
    hide_next      = hide;
    stat_next      = stat;
    key_next       = key;
    scan_off_next  = scan_off;
    pend_next      = pend;
    pend_off_next  = pend_off;
    we             = 1'b0;
    waddr          = '0;
    wdata          = '0;
    re             = 1'b0;
    raddr          = '0;
    to_find        = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          stat_next = dwc_pkg::STAT_OK;
          unique case (req_type)
            dwc_pkg::REQ_PUSH_FRONT: begin
              if (full) begin
                stat_next = dwc_pkg::STAT_FULL;
              end else begin
                head_next = (head == '0) ? IDX_W'(DEPTH - 1) : head - IDX_W'(1);
                we        = 1'b1;
                waddr     = head_next;
                wdata     = DATA_W'(value);
                if (empty) begin
                  cur_valid_next = 1'b1;
                  cur_next       = '0;
                end else if (cur_valid) begin
                  cur_next = cur + IDX_W'(1);
                end
                cnt_next = cnt + CNT_W'(1);
              end
            end
            dwc_pkg::REQ_PUSH_BACK: begin
              if (full) begin
                stat_next = dwc_pkg::STAT_FULL;
              end else begin
                we    = 1'b1;
                waddr = slot_of(head, cnt);
                wdata = DATA_W'(value);
                if (empty) begin
                  cur_valid_next = 1'b1;
                  cur_next       = '0;
                end
                cnt_next = cnt + CNT_W'(1);
              end
            end
            dwc_pkg::REQ_POP_FRONT: begin
              if (empty) begin
                stat_next = dwc_pkg::STAT_EMPTY;
              end else begin
                if (cnt == CNT_W'(1)) begin
                  cur_valid_next = 1'b0;
                  cur_next       = '0;
                end else if (cur_valid && cur != '0) begin
                  cur_next = cur - IDX_W'(1);
                end
                head_next = slot_of(head, CNT_W'(1));
                cnt_next  = cnt - CNT_W'(1);
              end
            end
            dwc_pkg::REQ_POP_BACK: begin
              if (empty) begin
                stat_next = dwc_pkg::STAT_EMPTY;
              end else begin
                if (cnt == CNT_W'(1)) begin
                  cur_valid_next = 1'b0;
                  cur_next       = '0;
                end else if (cur_valid && CNT_W'(cur) == cnt - CNT_W'(1)) begin
                  cur_next = IDX_W'(cnt - CNT_W'(2));
                end
                cnt_next = cnt - CNT_W'(1);
              end
            end
            dwc_pkg::REQ_HEAD: begin
              cur_valid_next = !empty;
              cur_next       = '0;
            end
            dwc_pkg::REQ_TAIL: begin
              cur_valid_next = !empty;
              cur_next       = empty ? '0 : IDX_W'(cnt - CNT_W'(1));
            end
            dwc_pkg::REQ_NEXT: begin
              if (cur_valid) begin
                if (CNT_W'(cur) + CNT_W'(1) >= cnt) begin
                  cur_valid_next = 1'b0;
                  cur_next       = '0;
                end else begin
                  cur_next = cur + IDX_W'(1);
                end
              end else begin
                cur_valid_next = !empty;
                cur_next       = '0;
              end
            end
            dwc_pkg::REQ_PREV: begin
              if (cur_valid) begin
                if (cur == '0) begin
                  cur_valid_next = 1'b0;
                end else begin
                  cur_next = cur - IDX_W'(1);
                end
              end else begin
                cur_valid_next = !empty;
                cur_next       = empty ? '0 : IDX_W'(cnt - CNT_W'(1));
              end
            end
            dwc_pkg::REQ_FIND: begin
              if (empty) begin
                cur_valid_next = 1'b0;
                cur_next       = '0;
              end else begin
                to_find = 1'b1;
              end
            end
            dwc_pkg::REQ_CLEAR: begin
              head_next      = '0;
              cnt_next       = '0;
              cur_valid_next = 1'b0;
              cur_next       = '0;
            end
            default: begin
            end
          endcase

          if (to_find) begin
            state_next    = S_FIND;
            key_next      = DATA_W'(value);
            scan_off_next = '0;
            pend_next     = 1'b0;
          end else begin
            // read the word under the cursor as it stands after the update
            state_next = S_FIN;
            hide_next  = !cur_valid_next;
            re         = cur_valid_next;
            raddr      = slot_of(head_next, CNT_W'(cur_next));
          end
        end
      end
      S_FIND: begin
        // one read issued and one compare per cycle, compare on the registered word of the earlier read
        if (match) begin
          cur_valid_next = 1'b1;
          cur_next       = pend_off;
          hide_next      = 1'b0;
          re             = 1'b1;
          raddr          = slot_of(head, CNT_W'(pend_off));
          state_next     = S_FIN;
        end else if (last) begin
          cur_valid_next = 1'b1;
          cur_next       = IDX_W'(cnt - CNT_W'(1));
          hide_next      = 1'b1;
          state_next     = S_FIN;
        end else begin
          re            = 1'b1;
          raddr         = slot_of(head, scan_off);
          pend_next     = 1'b1;
          pend_off_next = IDX_W'(scan_off);
          scan_off_next = scan_off + CNT_W'(1);
        end
      end
      S_FIN: begin
        if (load_out) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      cnt       <= '0;
      cur       <= '0;
      cur_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      cnt       <= cnt_next;
      cur       <= cur_next;
      cur_valid <= cur_valid_next;
      pend      <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    hide     <= hide_next;
    stat     <= stat_next;
    key      <= key_next;
    scan_off <= scan_off_next;
    pend_off <= pend_off_next;
  end

  // ring memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= (we && waddr == raddr) ? wdata : mem[raddr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      data       <= hide ? '0 : OUT_W'(rdata);
      data_valid <= !hide;
      status     <= stat;
      count      <= cnt;
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for deque_with_cursor. A directed sequence covers the
// empty, edge-of-queue and unused-code cases. It is followed by randomized
// bursts that fill, drain, walk the cursor and search the queue. Each result
// beat is checked against an in-bench mirror of the ring, the head pointer
// and the cursor.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH        = dwc_pkg::DEPTH_DEF;
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int RANDOM_ITEMS = 1700;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 16;
  localparam int CYCLE_LIMIT  = 500000;

  typedef struct packed {
    logic [dwc_pkg::REQ_W-1:0]   req;
    logic [dwc_pkg::VALUE_W-1:0] word;
  } request_t;

  typedef struct packed {
    logic [dwc_pkg::VALUE_W-1:0] data;
    logic                        dv;
    logic [dwc_pkg::STAT_W-1:0]  status;
    logic [CNT_W-1:0]            count;
  } result_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [dwc_pkg::REQ_W-1:0]   req_type = '0;
  logic [dwc_pkg::VALUE_W-1:0] value = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [dwc_pkg::VALUE_W-1:0] data;
  logic                        data_valid;
  logic [dwc_pkg::STAT_W-1:0]  status;
  logic [CNT_W-1:0]            count;

  request_t pending_reqs[$];
  result_t  expected_results[$];
  int       total_reqs = 0;
  int       sent = 0;
  int       error_count = 0;
  int       hold_left = 0;
  bit       hold_done = 1'b0;
  int       cycle_count = 0;

  // mirror of the queue
  logic [dwc_pkg::VALUE_W-1:0] ring_mirror[DEPTH];
  int                          head_idx = 0;
  int                          elem_cnt = 0;
  int                          cur_off = 0;
  bit                          cur_valid = 1'b0;

  deque_with_cursor dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .data       (data),
    .data_valid (data_valid),
    .status     (status),
    .count      (count)
  );

  always #4 clk = ~clk;

  function automatic int ring_slot(int off);
    return (head_idx + off) % DEPTH;
  endfunction

  // Applies one request to the mirror and returns the cursor report.
  function automatic result_t apply_request(logic [dwc_pkg::REQ_W-1:0] req,
                                            logic [dwc_pkg::VALUE_W-1:0] word);
    result_t                    r;
    logic [dwc_pkg::STAT_W-1:0] st;
    bit                         miss;
    int                         hit;
    st = dwc_pkg::STAT_OK;
    miss = 1'b0;
    hit = -1;
    case (req)
      dwc_pkg::REQ_PUSH_FRONT, dwc_pkg::REQ_PUSH_BACK: begin
        if (elem_cnt >= DEPTH) begin
          st = dwc_pkg::STAT_FULL;
        end else begin
          if (req == dwc_pkg::REQ_PUSH_FRONT) begin
            head_idx = (head_idx + DEPTH - 1) % DEPTH;
            ring_mirror[head_idx] = word;
            if (elem_cnt == 0) begin
              cur_valid = 1'b1;
              cur_off = 0;
            end else if (cur_valid) begin
              cur_off++;
            end
          end else begin
            ring_mirror[ring_slot(elem_cnt)] = word;
            if (elem_cnt == 0) begin
              cur_valid = 1'b1;
              cur_off = 0;
            end
          end
          elem_cnt++;
        end
      end
      dwc_pkg::REQ_POP_FRONT, dwc_pkg::REQ_POP_BACK: begin
        if (elem_cnt == 0) begin
          st = dwc_pkg::STAT_EMPTY;
        end else begin
          if (elem_cnt == 1) begin
            cur_valid = 1'b0;
            cur_off = 0;
          end else if (req == dwc_pkg::REQ_POP_FRONT) begin
            if (cur_valid && cur_off > 0) cur_off--;
          end else if (cur_valid && cur_off == elem_cnt - 1) begin
            cur_off = elem_cnt - 2;
          end
          if (req == dwc_pkg::REQ_POP_FRONT) head_idx = ring_slot(1);
          elem_cnt--;
        end
      end
      dwc_pkg::REQ_HEAD, dwc_pkg::REQ_TAIL: begin
        cur_valid = elem_cnt != 0;
        cur_off = (req == dwc_pkg::REQ_TAIL && elem_cnt != 0) ? elem_cnt - 1 : 0;
      end
      dwc_pkg::REQ_NEXT: begin
        if (cur_valid) begin
          if (cur_off + 1 >= elem_cnt) begin
            cur_valid = 1'b0;
            cur_off = 0;
          end else begin
            cur_off++;
          end
        end else begin
          cur_valid = elem_cnt != 0;
          cur_off = 0;
        end
      end
      dwc_pkg::REQ_PREV: begin
        if (cur_valid) begin
          if (cur_off == 0) cur_valid = 1'b0;
          else cur_off--;
        end else begin
          cur_valid = elem_cnt != 0;
          cur_off = elem_cnt != 0 ? elem_cnt - 1 : 0;
        end
      end
      dwc_pkg::REQ_FIND: begin
        for (int i = 0; i < elem_cnt && hit < 0; i++) begin
          if (ring_mirror[ring_slot(i)] == word) hit = i;
        end
        if (hit >= 0) begin
          cur_valid = 1'b1;
          cur_off = hit;
        end else begin
          // miss parks the cursor on the tail but reports nothing
          miss = 1'b1;
          cur_valid = elem_cnt != 0;
          cur_off = elem_cnt != 0 ? elem_cnt - 1 : 0;
        end
      end
      dwc_pkg::REQ_CLEAR: begin
        elem_cnt = 0;
        head_idx = 0;
        cur_valid = 1'b0;
        cur_off = 0;
      end
      default: ;
    endcase
    if (cur_valid && !miss && cur_off < elem_cnt) begin
      r.data = ring_mirror[ring_slot(cur_off)];
      r.dv = 1'b1;
    end else begin
      r.data = '0;
      r.dv = 1'b0;
    end
    r.status = st;
    r.count = CNT_W'(elem_cnt);
    return r;
  endfunction

  function automatic int traffic_phase();
    if (sent < total_reqs / 3) return 0;
    if (sent < 2 * total_reqs / 3) return 1;
    return 2;
  endfunction

  task automatic add_req(logic [dwc_pkg::REQ_W-1:0] req,
                         logic [dwc_pkg::VALUE_W-1:0] word);
    request_t r;
    r.req = req;
    r.word = word;
    pending_reqs.push_back(r);
  endtask

  task automatic report_field(string name, logic [dwc_pkg::VALUE_W-1:0] exp_v,
                              logic [dwc_pkg::VALUE_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    request_t r;
    int       idle_pct;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(apply_request(req_type, value));
        sent <= sent + 1;
      end
      if (!in_valid || !in_stall) begin
        case (traffic_phase())
          0: idle_pct = 15;
          1: idle_pct = 88;
          default: idle_pct = 0;
        endcase
        if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          r = pending_reqs.pop_front();
          in_valid <= 1'b1;
          req_type <= r.req;
          value <= r.word;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off once the no-idle phase starts, to back the block up
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && total_reqs > 0 && traffic_phase() == 2) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t exp_r;
    int      stall_pct;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result beat with none expected, actual data %h dv %b status %0d count %0d",
                   $time, data, data_valid, status, count);
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          report_field("data", exp_r.data, data);
          report_field("data_valid", dwc_pkg::VALUE_W'(exp_r.dv),
                       dwc_pkg::VALUE_W'(data_valid));
          report_field("status", dwc_pkg::VALUE_W'(exp_r.status),
                       dwc_pkg::VALUE_W'(status));
          report_field("count", dwc_pkg::VALUE_W'(exp_r.count),
                       dwc_pkg::VALUE_W'(count));
        end
      end
      case (traffic_phase())
        0: stall_pct = 88;
        1: stall_pct = 15;
        default: stall_pct = 0;
      endcase
      out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("deque_with_cursor test failed");
      $finish;
    end
  end

  initial begin
    int                          mode;
    int                          roll;
    int                          push_w;
    int                          pop_w;
    logic [dwc_pkg::REQ_W-1:0]   req;
    logic [dwc_pkg::VALUE_W-1:0] word;

    // empty-queue cases and unused codes
    add_req(dwc_pkg::REQ_POP_FRONT, 32'h0);
    add_req(dwc_pkg::REQ_POP_BACK, 32'hFFFF_FFFF);
    add_req(dwc_pkg::REQ_HEAD, 32'h0);
    add_req(dwc_pkg::REQ_TAIL, 32'h0);
    add_req(dwc_pkg::REQ_NEXT, 32'h0);
    add_req(dwc_pkg::REQ_PREV, 32'h0);
    add_req(dwc_pkg::REQ_FIND, 32'h0);
    add_req(4'd10, 32'h0);
    add_req(4'd15, 32'hFFFF_FFFF);
    // build a short queue, walk off both ends
    add_req(dwc_pkg::REQ_PUSH_BACK, 32'h0);
    add_req(dwc_pkg::REQ_PUSH_FRONT, 32'hFFFF_FFFF);
    add_req(dwc_pkg::REQ_PUSH_BACK, 32'h5A5A_5A5A);
    add_req(dwc_pkg::REQ_NEXT, 32'h0);
    add_req(dwc_pkg::REQ_NEXT, 32'h0);
    add_req(dwc_pkg::REQ_PREV, 32'h0);
    add_req(dwc_pkg::REQ_POP_BACK, 32'h0);
    add_req(dwc_pkg::REQ_HEAD, 32'h0);
    add_req(dwc_pkg::REQ_POP_FRONT, 32'h0);
    add_req(dwc_pkg::REQ_FIND, 32'h0);
    add_req(dwc_pkg::REQ_FIND, 32'h1234_5678);
    add_req(dwc_pkg::REQ_PREV, 32'h0);
    add_req(dwc_pkg::REQ_PUSH_FRONT, 32'hA5A5_A5A5);
    add_req(dwc_pkg::REQ_POP_BACK, 32'h0);
    add_req(dwc_pkg::REQ_CLEAR, 32'h0);
    add_req(dwc_pkg::REQ_PUSH_FRONT, 32'h8000_0001);

    // bursts: fill, drain, cursor walk, balanced
    mode = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 24 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: begin push_w = 65; pop_w = 10; end
        1: begin push_w = 10; pop_w = 65; end
        2: begin push_w = 15; pop_w = 15; end
        default: begin push_w = 30; pop_w = 30; end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 2) begin
        req = dwc_pkg::REQ_CLEAR;
      end else if (roll < 4) begin
        req = dwc_pkg::REQ_W'($urandom_range(10, 15));
      end else if (roll < 4 + push_w) begin
        req = $urandom_range(0, 1) ? dwc_pkg::REQ_PUSH_BACK : dwc_pkg::REQ_PUSH_FRONT;
      end else if (roll < 4 + push_w + pop_w) begin
        req = $urandom_range(0, 1) ? dwc_pkg::REQ_POP_BACK : dwc_pkg::REQ_POP_FRONT;
      end else begin
        req = dwc_pkg::REQ_W'($urandom_range(4, 8));
      end
      // small value pool so finds hit and duplicates occur
      word = $urandom_range(0, 1) ? dwc_pkg::VALUE_W'($urandom_range(0, 7))
                                  : dwc_pkg::VALUE_W'($urandom);
      add_req(req, word);
    end
    total_reqs = pending_reqs.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (sent < total_reqs || expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_results.size() == 0) begin
      $display("deque_with_cursor test passed");
    end else begin
      $display("deque_with_cursor test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/dwc_pkg.sv
hw/rtl/deque_with_cursor.sv
verif/tb_top.sv
